@@ rtl/core/smacc_pkg.sv @@
// Shared types, opcodes and status codes for the sign-magnitude accumulator ALU.
`timescale 1ns / 1ps

package smacc_pkg;

	localparam int WORD_W = 15;
	localparam int MAG_W  = 14;
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_OR   = 3'd4;
	localparam logic [OP_W-1:0] OP_LOAD = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FETCH = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DIV0  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   req_type;
		logic [WORD_W-1:0] memory_word;
		logic              fetch_failed;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] acc_value;
		logic [STAT_W-1:0] status;
	} out_t;

	// Control from the sequencer to the serial datapath.
	typedef struct packed {
		logic            load;
		logic            step;
		logic [OP_W-1:0] op;
	} ser_ctrl_t;

	// State of the serial datapath as seen by the sequencer.
	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] p;
		logic              borrow;
	} ser_res_t;

endpackage

@@ rtl/core/smacc_serial.sv @@
// Bit-serial datapath: serial add and subtract, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module smacc_serial (
	input  logic                          clk,
	input  smacc_pkg::ser_ctrl_t          ctrl,
	input  logic [smacc_pkg::MAG_W-1:0]   mag_a,
	input  logic [smacc_pkg::MAG_W-1:0]   mag_b,
	output smacc_pkg::ser_res_t           res
);

	logic [smacc_pkg::WORD_W-1:0] x_q, y_q, p_q;
	logic [smacc_pkg::WORD_W-1:0] x_d, y_d, p_d;
	logic                         c_q, b1_q, b2_q;
	logic                         c_d, b1_d, b2_d;

	logic                         xb, yb, hx;
	logic [smacc_pkg::WORD_W-1:0] part;
	logic [smacc_pkg::WORD_W-1:0] diff;

	always_comb begin
		xb   = x_q[0];
		yb   = y_q[0];
		hx   = xb ^ yb;
		part = {p_q[smacc_pkg::WORD_W-2:0], x_q[smacc_pkg::WORD_W-1]};
		diff = part - y_q;
		x_d  = x_q;
		y_d  = y_q;
		p_d  = p_q;
		c_d  = c_q;
		b1_d = b1_q;
		b2_d = b2_q;
		case (ctrl.op)
			smacc_pkg::OP_ADD, smacc_pkg::OP_SUB: begin
				// Sum and both differences come out one bit a cycle while step is high, LSB first.
				p_d  = {hx ^ c_q, p_q[smacc_pkg::WORD_W-1:1]};
				x_d  = {hx ^ b1_q, x_q[smacc_pkg::WORD_W-1:1]};
				y_d  = {hx ^ b2_q, y_q[smacc_pkg::WORD_W-1:1]};
				c_d  = (xb & yb) | (hx & c_q);
				b1_d = (~xb & yb) | (~hx & b1_q);
				b2_d = (~yb & xb) | (~hx & b2_q);
			end
			smacc_pkg::OP_MUL: begin
				if (yb) begin
					p_d = p_q + x_q;
				end
				x_d = {x_q[smacc_pkg::WORD_W-2:0], 1'b0};
				y_d = {1'b0, y_q[smacc_pkg::WORD_W-1:1]};
			end
			smacc_pkg::OP_DIV: begin
				if (part >= y_q) begin
					p_d = diff;
					x_d = {x_q[smacc_pkg::WORD_W-2:0], 1'b1};
				end else begin
					p_d = part;
					x_d = {x_q[smacc_pkg::WORD_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q  <= {1'b0, mag_a};
			y_q  <= {1'b0, mag_b};
			p_q  <= '0;
			c_q  <= 1'b0;
			b1_q <= 1'b0;
			b2_q <= 1'b0;
		end else if (ctrl.step) begin
			x_q  <= x_d;
			y_q  <= y_d;
			p_q  <= p_d;
			c_q  <= c_d;
			b1_q <= b1_d;
			b2_q <= b2_d;
		end
	end

	assign res.x      = x_q;
	assign res.y      = y_q;
	assign res.p      = p_q;
	assign res.borrow = b1_q;

endmodule

@@ rtl/core/sign_magnitude_accumulator_alu.sv @@
// Top level of the sign-magnitude accumulator ALU: sequencer, accumulator and result register.
`timescale 1ns / 1ps

// This block keeps a 15-bit sign-magnitude accumulator (bit 14 sign, bits 13..0 magnitude)
// and applies one operation per input transaction against the fetched operand word, then
// returns the new accumulator and a status in exactly one output transaction. Add, subtract,
// multiply and divide run through a bit-serial datapath one bit per cycle over fifteen steps:
// such a transaction loads the operands at acceptance, runs the fifteen serial steps and then
// registers the result in a writeback state. Logical OR, load, unused opcodes, fetch faults
// and division by zero skip the serial steps and go straight to writeback. The serial step
// count is what sets the rate. A new input transaction is taken as soon as the previous one
// has been written back, even while its result still waits in the output register; writeback
// waits only if that register is still full. Negative results are stored as magnitude with
// the sign set and the magnitude masked to 14 bits, a zero result of add, subtract or divide
// is positive zero, and a faulted or zero-divisor operation leaves the accumulator as it was.
module sign_magnitude_accumulator_alu (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  smacc_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output smacc_pkg::out_t  out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	localparam logic [3:0] LAST_STEP = 4'(smacc_pkg::WORD_W - 1);

	logic [1:0]                     state_q;
	logic [3:0]                     cnt_q;
	logic                           out_valid_q;
	smacc_pkg::out_t                out_data_q;
	logic [smacc_pkg::WORD_W-1:0]   acc_q;
	logic [smacc_pkg::OP_W-1:0]     op_q;
	logic [smacc_pkg::WORD_W-1:0]   word_q;
	logic                           fail_q;

	logic                           accept;
	logic                           commit;
	logic                           serial_op;
	smacc_pkg::ser_ctrl_t           ctrl;
	smacc_pkg::ser_res_t            res;

	logic                           sa, sb, sbe, same, sgn, nz;
	logic [smacc_pkg::MAG_W-1:0]    ma, mb;
	logic [smacc_pkg::WORD_W-1:0]   mag;
	logic [smacc_pkg::WORD_W-1:0]   new_acc;
	logic [smacc_pkg::STAT_W-1:0]   new_status;

	// The input side is open only while nothing is in flight.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign commit   = (state_q == ST_WB) && (!out_valid_q || !out_stall);

	// Only the arithmetic operations with a usable operand need the serial steps.
	always_comb begin
		serial_op = 1'b0;
		if (!in_data.fetch_failed) begin
			if (in_data.req_type inside {smacc_pkg::OP_ADD, smacc_pkg::OP_SUB,
						smacc_pkg::OP_MUL}) begin
				serial_op = 1'b1;
			end else if (in_data.req_type == smacc_pkg::OP_DIV) begin
				serial_op = |in_data.memory_word[smacc_pkg::MAG_W-1:0];
			end
		end
	end

	// At acceptance the datapath takes the accumulator and operand magnitudes.
	assign ctrl.load = accept;
	assign ctrl.step = (state_q == ST_RUN);
	assign ctrl.op   = op_q;

	smacc_serial u_serial (
		.clk   (clk),
		.ctrl  (ctrl),
		.mag_a (acc_q[smacc_pkg::MAG_W-1:0]),
		.mag_b (in_data.memory_word[smacc_pkg::MAG_W-1:0]),
		.res   (res)
	);

	// Writeback: signs are applied here, the serial unit works on magnitudes only.
	always_comb begin
		sa  = acc_q[smacc_pkg::WORD_W-1];
		ma  = acc_q[smacc_pkg::MAG_W-1:0];
		sb  = word_q[smacc_pkg::WORD_W-1];
		mb  = word_q[smacc_pkg::MAG_W-1:0];
		sbe = sb ^ (op_q == smacc_pkg::OP_SUB);
		same = (sa == sbe);
		mag = res.p;
		sgn = sa ^ sb;
		nz  = 1'b0;
		new_acc    = acc_q;
		new_status = smacc_pkg::STAT_OK;
		case (op_q)
			smacc_pkg::OP_ADD, smacc_pkg::OP_SUB: begin
				// With unlike signs the final borrow says which difference is the magnitude.
				if (same) begin
					mag = res.p;
					sgn = sa;
				end else if (res.borrow) begin
					mag = res.y;
					sgn = sbe;
				end else begin
					mag = res.x;
					sgn = sa;
				end
				nz = |mag;
			end
			smacc_pkg::OP_MUL: begin
				// Only the low bits of the product are kept, so zero-ness comes from the operands.
				mag = res.p;
				nz  = (|ma) && (|mb);
			end
			smacc_pkg::OP_DIV: begin
				mag = res.x;
				nz  = |res.x;
			end
			default: begin
			end
		endcase
		case (op_q)
			smacc_pkg::OP_ADD, smacc_pkg::OP_SUB, smacc_pkg::OP_MUL, smacc_pkg::OP_DIV: begin
				new_acc = (sgn && nz) ? {1'b1, mag[smacc_pkg::MAG_W-1:0]} : mag;
			end
			smacc_pkg::OP_OR: begin
				new_acc = {{(smacc_pkg::WORD_W-1){1'b0}}, (|ma) || (|mb)};
			end
			smacc_pkg::OP_LOAD: begin
				new_acc = word_q;
			end
			default: begin
				new_acc = acc_q;
			end
		endcase
		if (op_q <= smacc_pkg::OP_LOAD) begin
			if (fail_q) begin
				new_acc    = acc_q;
				new_status = smacc_pkg::STAT_FETCH;
			end else if ((op_q == smacc_pkg::OP_DIV) && !(|mb)) begin
				new_acc    = acc_q;
				new_status = smacc_pkg::STAT_DIV0;
			end
		end else begin
			new_acc = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= serial_op ? ST_RUN : ST_WB;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				acc_q       <= new_acc;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The operation and operand are held for the writeback.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_data.req_type;
			word_q <= in_data.memory_word;
			fail_q <= in_data.fetch_failed;
		end
		if (commit) begin
			out_data_q.acc_value <= new_acc;
			out_data_q.status    <= new_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) || (state_q == ST_WB))
		else $error("accepted transaction did not start work");

	a_acc_only_at_wb: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(acc_q))
		else $error("accumulator changed outside writeback");

	a_fault_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (new_status != smacc_pkg::STAT_OK) |=> $stable(acc_q))
		else $error("faulted transaction changed the accumulator");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && (state_q == ST_IDLE))
		else $error("writeback did not present a result");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q <= LAST_STEP))
		else $error("serial step count out of range");
`endif

endmodule
